// File: hdl/utf8v_pkg.sv
// shared types, byte bounds and class codes of the utf-8 stream validator
package utf8v_pkg;

    localparam int BPW_DEFAULT = 8;
    localparam int BPW_MAX     = 8;

    // bound class on the next continuation byte
    localparam logic [2:0] CLS_NORMAL = 3'd0;
    localparam logic [2:0] CLS_E0     = 3'd1;
    localparam logic [2:0] CLS_ED     = 3'd2;
    localparam logic [2:0] CLS_F0     = 3'd3;
    localparam logic [2:0] CLS_F4     = 3'd4;

    localparam logic [7:0] B_ASCII_MAX = 8'h7F;
    localparam logic [7:0] B_CONT_MIN  = 8'h80;
    localparam logic [7:0] B_L2_MIN    = 8'hC2;
    localparam logic [7:0] B_L2_MAX    = 8'hDF;
    localparam logic [7:0] B_CONT_MAX  = 8'hBF;
    localparam logic [7:0] B_E0        = 8'hE0;
    localparam logic [7:0] B_A0        = 8'hA0;
    localparam logic [7:0] B_ED        = 8'hED;
    localparam logic [7:0] B_9F        = 8'h9F;
    localparam logic [7:0] B_F0        = 8'hF0;
    localparam logic [7:0] B_90        = 8'h90;
    localparam logic [7:0] B_F4        = 8'hF4;
    localparam logic [7:0] B_8F        = 8'h8F;
    localparam logic [7:0] B_EF        = 8'hEF;

    // what one lane finds about its byte
    typedef struct packed {
        logic [7:0] cont_ok;    // legal as continuation, indexed by class code
        logic       lead_bad;   // not a legal lead byte
        logic [1:0] lead_pend;  // continuations owed after this lead
        logic [2:0] lead_cls;   // bound class after this lead
    } t_lane_info;

    typedef struct packed {
        logic error_so_far;
        logic message_valid;
        logic message_done;
    } t_result;

endpackage

// File: hdl/utf8v_lane.sv
// one byte lane: classifies a byte as lead or continuation under every bound
module utf8v_lane
    import utf8v_pkg::*;
(
    input  logic [7:0]  i_byte,
    output t_lane_info  o_info
);

    logic base_cont;

    always_comb begin
        base_cont = (i_byte >= B_CONT_MIN) && (i_byte <= B_CONT_MAX);

        // unused class codes behave as the normal bound
        o_info.cont_ok             = {8{base_cont}};
        o_info.cont_ok[CLS_E0]     = (i_byte >= B_A0) && (i_byte <= B_CONT_MAX);
        o_info.cont_ok[CLS_ED]     = (i_byte >= B_CONT_MIN) && (i_byte <= B_9F);
        o_info.cont_ok[CLS_F0]     = (i_byte >= B_90) && (i_byte <= B_CONT_MAX);
        o_info.cont_ok[CLS_F4]     = (i_byte >= B_CONT_MIN) && (i_byte <= B_8F);

        o_info.lead_bad  = 1'b0;
        o_info.lead_pend = 2'd0;
        o_info.lead_cls  = CLS_NORMAL;
        if (i_byte <= B_ASCII_MAX) begin
            o_info.lead_pend = 2'd0;
        end else if ((i_byte >= B_L2_MIN) && (i_byte <= B_L2_MAX)) begin
            o_info.lead_pend = 2'd1;
        end else if ((i_byte >= B_E0) && (i_byte <= B_EF)) begin
            o_info.lead_pend = 2'd2;
            if (i_byte == B_E0) begin
                o_info.lead_cls = CLS_E0;
            end else if (i_byte == B_ED) begin
                o_info.lead_cls = CLS_ED;
            end
        end else if ((i_byte >= B_F0) && (i_byte <= B_F4)) begin
            o_info.lead_pend = 2'd3;
            if (i_byte == B_F0) begin
                o_info.lead_cls = CLS_F0;
            end else if (i_byte == B_F4) begin
                o_info.lead_cls = CLS_F4;
            end
        end else begin
            o_info.lead_bad = 1'b1;
        end
    end

endmodule

// File: hdl/utf8v_merge.sv
// merge stage: chains the lane findings through the cross-word sequence state
module utf8v_merge
    import utf8v_pkg::*;
#(
    parameter int BYTES_PER_WORD = BPW_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  t_lane_info                i_lane [BYTES_PER_WORD],
    input  logic [BYTES_PER_WORD-1:0] i_lane_en,
    input  logic                      i_last,
    output t_result                   o_result
);

    logic [1:0] r_pend;
    logic [2:0] r_cls;
    logic       r_err;
    logic [1:0] n_pend;
    logic [2:0] n_cls;
    logic       n_err;
    logic [1:0] w_pend;
    logic [2:0] w_cls;
    logic       w_err;
    logic       err_out;

    // walk the lanes in address order over the narrow state
    always_comb begin
        w_pend = r_pend;
        w_cls  = r_cls;
        w_err  = r_err;
        for (int i = 0; i < BYTES_PER_WORD; i++) begin
            if (i_lane_en[i] && !w_err) begin
                if (w_pend != 2'd0) begin
                    if (!i_lane[i].cont_ok[w_cls]) begin
                        w_err  = 1'b1;
                        w_pend = 2'd0;
                    end else begin
                        w_pend = w_pend - 2'd1;
                    end
                    w_cls = CLS_NORMAL;
                end else if (i_lane[i].lead_bad) begin
                    w_err = 1'b1;
                end else begin
                    w_pend = i_lane[i].lead_pend;
                    w_cls  = i_lane[i].lead_cls;
                end
            end
        end

        // a sequence still open at the end of the message is ill formed
        err_out = w_err || (i_last && (w_pend != 2'd0));
        o_result.error_so_far  = err_out;
        o_result.message_valid = i_last && !err_out;
        o_result.message_done  = i_last;

        if (i_last) begin
            n_pend = 2'd0;
            n_cls  = CLS_NORMAL;
            n_err  = 1'b0;
        end else begin
            n_pend = w_pend;
            n_cls  = w_cls;
            n_err  = w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_cls  <= CLS_NORMAL;
            r_err  <= 1'b0;
        end else if (i_en) begin
            r_pend <= n_pend;
            r_cls  <= n_cls;
            r_err  <= n_err;
        end
    end

endmodule

// File: hdl/utf8_stream_validator.sv
// top level of the utf-8 stream validator: lanes, stage register, merge, output skid
//
// input channel: i_valid / o_stall with i_word_bytes, i_byte_count, i_end_of_message.
// a word is taken at a rising edge with i_valid high and o_stall low. bytes are
// checked in address order from the low byte; a count above BYTES_PER_WORD is
// treated as BYTES_PER_WORD, a count of zero checks no bytes.
// output channel: o_valid / i_stall, one verdict word per input word, in order.
// o_message_valid and o_message_done are only meaningful on the last word.
// two register stages, the stage register and the output register, in that order.
// throughput: one word per cycle while o_stall is low.
// the lane classification and the walk of the merge stage, one step per lane, over the
// 2-bit pending count and 3-bit bound class set the cycle time.
// a two-entry output buffer keeps i_stall off the o_stall path; o_stall rises only
// when both entries and the stage register are full, and depends on registers only,
// so i_stall reaches o_stall only through the skid entry register.
// synchronous active-low reset empties the pipeline and clears the sequence
// state; state also clears after every last word of a message.
module utf8_stream_validator
    import utf8v_pkg::*;
#(
    parameter int BYTES_PER_WORD = BPW_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_word_bytes,
    input  logic [3:0]  i_byte_count,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_error_so_far,
    output logic        o_message_valid,
    output logic        o_message_done
);

    t_lane_info                lane_info [BYTES_PER_WORD];
    logic [BYTES_PER_WORD-1:0] lane_en;

    t_lane_info                r_lane [BYTES_PER_WORD];
    logic [BYTES_PER_WORD-1:0] r_lane_en;
    logic                      r_last;
    logic                      r_v1;

    t_result                   merge_res;
    t_result                   r_out;
    t_result                   r_skid;
    logic                      r_ov;
    logic                      r_sv;

    logic                      s1_en;
    logic                      adv2;
    logic                      pop;

    for (genvar g = 0; g < BYTES_PER_WORD; g++) begin : g_lane
        utf8v_lane u_lane (
            .i_byte (i_word_bytes[8*g +: 8]),
            .o_info (lane_info[g])
        );
        assign lane_en[g] = (i_byte_count > 4'(g));
    end

    assign pop     = r_ov && !i_stall;
    assign adv2    = r_v1 && !r_sv;
    assign s1_en   = !r_v1 || adv2;
    assign o_stall = !s1_en;

    // stage register between lanes and merge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s1_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_lane    <= lane_info;
            r_lane_en <= lane_en;
            r_last    <= i_end_of_message;
        end
    end

    utf8v_merge #(
        .BYTES_PER_WORD (BYTES_PER_WORD)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv2),
        .i_lane    (r_lane),
        .i_lane_en (r_lane_en),
        .i_last    (r_last),
        .o_result  (merge_res)
    );

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (pop) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= adv2;
            end
        end else if (adv2) begin
            if (!r_ov) begin
                r_ov <= 1'b1;
            end else begin
                r_sv <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_sv) begin
                r_out <= r_skid;
            end else if (adv2) begin
                r_out <= merge_res;
            end
        end else if (adv2) begin
            if (!r_ov) begin
                r_out <= merge_res;
            end else begin
                r_skid <= merge_res;
            end
        end
    end

    assign o_valid         = r_ov;
    assign o_error_so_far  = r_out.error_so_far;
    assign o_message_valid = r_out.message_valid;
    assign o_message_done  = r_out.message_done;

endmodule

// File: hdl/utf8v_checker.sv
// port-level checks of the utf-8 stream validator and their bind
module utf8v_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_stall,
    input logic o_error_so_far,
    input logic o_message_valid,
    input logic o_message_done
);

    // a verdict of well formed only comes on the last word
    a_valid_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_message_valid |-> o_message_done)
        else $error("message_valid outside last word");

    // a well-formed verdict never carries an error
    a_valid_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_message_valid |-> !o_error_so_far)
        else $error("message_valid with error");

    // a clean last word must be reported as well formed
    a_clean_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_message_done && !o_error_so_far |-> o_message_valid)
        else $error("clean last word not marked valid");

    // a stalled output word holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_error_so_far)
            && $stable(o_message_valid) && $stable(o_message_done))
        else $error("output word changed under stall");

endmodule

bind utf8_stream_validator utf8v_checker u_utf8v_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_error_so_far  (o_error_so_far),
    .o_message_valid (o_message_valid),
    .o_message_done  (o_message_done)
);
